// ===== design/bth_pkg.sv =====
// Shared types, codes and helpers for the boundary-tag heap allocator.
// Depends on nothing; every other design file imports it.
`default_nettype none
package bth_pkg;

    localparam int ADDR_W      = 7;
    localparam int DATA_W      = 8;
    localparam int MAX_RESULTS = 64;

    localparam logic [2:0] MODE_ALLOC = 3'd0;
    localparam logic [2:0] MODE_FREE  = 3'd1;
    localparam logic [2:0] MODE_WRITE = 3'd2;
    localparam logic [2:0] MODE_READ  = 3'd3;
    localparam logic [2:0] MODE_LIST  = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    typedef struct packed {
        logic              last;
        logic [DATA_W-1:0] read_data;
        logic [1:0]        status;
        logic              allocated;
        logic [ADDR_W-1:0] payload_size;
        logic [ADDR_W-1:0] address_out;
    } t_result;

    function automatic logic [DATA_W-1:0] f_tag(input logic [ADDR_W-1:0] size,
                                                input logic alloc);
        return {size, alloc};
    endfunction

    function automatic t_result f_res(input logic [ADDR_W-1:0] addr,
                                      input logic [ADDR_W-1:0] psize,
                                      input logic alloc, input logic [1:0] status,
                                      input logic [DATA_W-1:0] rdata,
                                      input logic last);
        t_result r;
        r.address_out  = addr;
        r.payload_size = psize;
        r.allocated    = alloc;
        r.status       = status;
        r.read_data    = rdata;
        r.last         = last;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== design/bth_ram.sv =====
// Heap byte memory: one write port, one read port, registered read data.
// Depends on bth_pkg for the address and data widths.
`default_nettype none
module bth_ram
    import bth_pkg::*;
#(
    parameter int DEPTH = 127
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);
    localparam int AW = $clog2(DEPTH);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr[AW-1:0]] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr[AW-1:0]];
    end

endmodule
`default_nettype wire

// ===== design/boundary_tag_heap_allocator.sv =====
// Top level of the boundary-tag heap allocator: command sequencer around the heap memory.
// Depends on bth_pkg and bth_ram.
//
// Usage: requests enter on the s_axis channel; results leave on m_axis.
// A request carries a mode (alloc, free, write byte, read byte, list blocks)
// and its operands. Each request gives one result, except list, which gives
// one result per heap block, and the unused modes, which give none. The last
// result of a request has m_axis_tlast set.
// The block works on one request at a time; s_axis_tready is high only while
// it is idle. Every heap access goes through the single synchronous memory,
// one access per cycle with registered read data. An alloc walks the blocks
// first fit and then writes two or four tags; a free writes the block's tags,
// clears its payload and merges with any free neighbor on either side; a list
// reads and checks each block and hands over its result before the next. A new
// request is taken only once the last result, if any, has been taken. The
// longest request is a list of 63 small blocks.
// After reset, a clearing pass writes the memory to a single free block
// spanning the heap; no request is taken during the pass.
// Results sit in an output register; while the receiver stalls, the
// sequencer holds and resumes (for list, with the next block) once the
// result is taken.
`default_nettype none
module boundary_tag_heap_allocator
    import bth_pkg::*;
#(
    parameter int HEAP_BYTES = 127
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // mode[2:0], request_size[9:3], address[16:10], write_data[24:17], zero fill
    input  wire logic [31:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // address_out[6:0], payload_size[13:7], allocated[14], status[16:15],
    // read_data[24:17], zero fill
    output logic      [31:0] m_axis_tdata,
    output logic             m_axis_tlast
);
    localparam logic [7:0] HEAP = 8'(HEAP_BYTES);
    localparam logic [ADDR_W-1:0] HEAP_LAST = ADDR_W'(HEAP_BYTES - 1);
    localparam logic [DATA_W-1:0] END_TAG = {ADDR_W'(HEAP_BYTES), 1'b0};

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_OUT,
        A_RD, A_CHK, A_W1, A_W2, A_W3, A_W4,
        F_RD, F_CHK, F_WH, F_WF, F_Z, F_NSEL, F_NRD, F_NCHK,
        F_N1, F_N2, F_N3, F_N4, F_PSEL, F_PRD, F_PCHK,
        F_P1, F_P2, F_P3, F_P4,
        W_DO, R_RD, R_Q, L_RD
    } t_state;

    t_state r_state, r_ret;
    logic [ADDR_W-1:0] r_i, r_h, r_j, r_s, r_n, r_s1, r_s2, r_addr;
    logic [DATA_W-1:0] r_wd;
    logic [7:0]        r_need;
    logic              r_split;
    logic [5:0]        r_cnt;
    logic              r_listing;
    logic              r_o_valid;
    t_result           r_out;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [DATA_W-1:0] mem_wdata, mem_q;

    bth_ram #(.DEPTH(HEAP_BYTES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_q)
    );

    // Request fields.
    logic [2:0]        in_mode;
    logic [ADDR_W-1:0] in_req, in_addr;
    logic [DATA_W-1:0] in_wd;
    assign in_mode = s_axis_tdata[2:0];
    assign in_req  = s_axis_tdata[9:3];
    assign in_addr = s_axis_tdata[16:10];
    assign in_wd   = s_axis_tdata[24:17];

    // Decode of the tag just read from memory.
    logic [ADDR_W-1:0] q_size;
    logic              q_alloc;
    logic [7:0]        sum_i, sum_n, h_end, j_next;
    logic              zero_more;
    assign q_size    = mem_q[7:1];
    assign q_alloc   = mem_q[0];
    assign sum_i     = {1'b0, r_i} + {1'b0, q_size};
    assign h_end     = {1'b0, r_h} + {1'b0, r_s};
    assign sum_n     = h_end + {1'b0, q_size};
    assign j_next    = {1'b0, r_j} + 8'd1;
    assign zero_more = j_next < h_end;

    // Memory port control.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_i;
        mem_wdata = '0;
        mem_raddr = r_i;
        unique case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_wdata = (r_i == '0 || r_i == HEAP_LAST) ? END_TAG : '0;
            end
            A_W1: begin
                mem_we    = 1'b1;
                mem_wdata = f_tag(r_n, 1'b1);
            end
            A_W2: begin
                mem_we    = 1'b1;
                mem_waddr = r_i + r_n - ADDR_W'(1);
                mem_wdata = f_tag(r_n, 1'b1);
            end
            A_W3: begin
                mem_we    = 1'b1;
                mem_waddr = r_i + r_n;
                mem_wdata = f_tag(r_s - r_n, 1'b0);
            end
            A_W4: begin
                mem_we    = 1'b1;
                mem_waddr = r_i + r_s - ADDR_W'(1);
                mem_wdata = f_tag(r_s - r_n, 1'b0);
            end
            F_RD:  mem_raddr = r_h;
            F_WH, F_N3: begin
                mem_we    = 1'b1;
                mem_waddr = r_h;
                mem_wdata = f_tag(r_s, 1'b0);
            end
            F_WF, F_N4: begin
                mem_we    = 1'b1;
                mem_waddr = r_h + r_s - ADDR_W'(1);
                mem_wdata = f_tag(r_s, 1'b0);
            end
            F_Z: begin
                mem_we    = zero_more;
                mem_waddr = r_j;
            end
            F_NRD: mem_raddr = r_h + r_s;
            F_N1: begin
                mem_we    = 1'b1;
                mem_waddr = r_h + r_s - ADDR_W'(1);
            end
            F_N2: begin
                mem_we    = 1'b1;
                mem_waddr = r_h + r_s;
            end
            F_PRD: mem_raddr = r_h - ADDR_W'(1);
            F_P1: begin
                mem_we    = 1'b1;
                mem_waddr = r_h - ADDR_W'(1);
            end
            F_P2: begin
                mem_we    = 1'b1;
                mem_waddr = r_h;
            end
            F_P3: begin
                mem_we    = 1'b1;
                mem_waddr = r_h - r_s1;
                mem_wdata = f_tag(r_s1 + r_s, 1'b0);
            end
            F_P4: begin
                mem_we    = 1'b1;
                mem_waddr = r_h + r_s - ADDR_W'(1);
                mem_wdata = f_tag(r_s1 + r_s, 1'b0);
            end
            W_DO: begin
                mem_we    = 1'b1;
                mem_waddr = r_addr;
                mem_wdata = r_wd;
            end
            R_RD:  mem_raddr = r_addr;
            default: ;
        endcase
    end

    // Sequencer: state and registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_ret     <= S_IDLE;
            r_i       <= '0;
            r_o_valid <= 1'b0;
            r_listing <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLR: begin
                    if (r_i == HEAP_LAST) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_i <= r_i + ADDR_W'(1);
                    end
                end
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_addr <= in_addr;
                        r_wd   <= in_wd;
                        r_ret  <= S_IDLE;
                        case (in_mode)
                            MODE_ALLOC: begin
                                r_need  <= {1'b0, in_req} + 8'd2;
                                r_i     <= '0;
                                r_state <= A_RD;
                            end
                            MODE_FREE: begin
                                if (in_addr == '0 || {1'b0, in_addr} > HEAP) begin
                                    r_out     <= f_res('0, '0, 1'b0, ST_BAD, '0, 1'b1);
                                    r_o_valid <= 1'b1;
                                    r_state   <= S_OUT;
                                end else begin
                                    r_h     <= in_addr - ADDR_W'(1);
                                    r_state <= F_RD;
                                end
                            end
                            MODE_WRITE, MODE_READ: begin
                                if ({1'b0, in_addr} >= HEAP) begin
                                    r_out     <= f_res('0, '0, 1'b0, ST_BAD, '0, 1'b1);
                                    r_o_valid <= 1'b1;
                                    r_state   <= S_OUT;
                                end else begin
                                    r_state <= (in_mode == MODE_WRITE) ? W_DO : R_RD;
                                end
                            end
                            MODE_LIST: begin
                                r_i       <= '0;
                                r_cnt     <= '0;
                                r_listing <= 1'b1;
                                r_state   <= L_RD;
                            end
                            default: ;
                        endcase
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_o_valid <= 1'b0;
                        r_state   <= r_ret;
                    end
                end
                A_RD: r_state <= A_CHK;
                A_CHK: begin
                    if (q_size < ADDR_W'(2) || sum_i > HEAP) begin
                        r_out     <= f_res('0, '0, 1'b0, ST_FULL, '0, 1'b1);
                        r_o_valid <= 1'b1;
                        r_state   <= S_OUT;
                    end else if (!q_alloc && {1'b0, q_size} >= r_need) begin
                        r_s <= q_size;
                        if ({1'b0, q_size} - r_need >= 8'd2) begin
                            r_n     <= r_need[ADDR_W-1:0];
                            r_split <= 1'b1;
                        end else begin
                            r_n     <= q_size;
                            r_split <= 1'b0;
                        end
                        r_state <= A_W1;
                    end else if (sum_i >= HEAP) begin
                        r_out     <= f_res('0, '0, 1'b0, ST_FULL, '0, 1'b1);
                        r_o_valid <= 1'b1;
                        r_state   <= S_OUT;
                    end else begin
                        r_i     <= sum_i[ADDR_W-1:0];
                        r_state <= A_RD;
                    end
                end
                A_W1: r_state <= A_W2;
                A_W2: begin
                    if (r_split) begin
                        r_state <= A_W3;
                    end else begin
                        r_out     <= f_res(r_i + ADDR_W'(1), '0, 1'b0, ST_OK, '0, 1'b1);
                        r_o_valid <= 1'b1;
                        r_state   <= S_OUT;
                    end
                end
                A_W3: r_state <= A_W4;
                A_W4: begin
                    r_out     <= f_res(r_i + ADDR_W'(1), '0, 1'b0, ST_OK, '0, 1'b1);
                    r_o_valid <= 1'b1;
                    r_state   <= S_OUT;
                end
                F_RD: r_state <= F_CHK;
                F_CHK: begin
                    if (q_size < ADDR_W'(2) || ({1'b0, r_h} + {1'b0, q_size}) > HEAP) begin
                        r_out     <= f_res('0, '0, 1'b0, ST_BAD, '0, 1'b1);
                        r_o_valid <= 1'b1;
                        r_state   <= S_OUT;
                    end else begin
                        r_s     <= q_size;
                        r_state <= F_WH;
                    end
                end
                F_WH: r_state <= F_WF;
                F_WF: begin
                    r_j     <= r_h + ADDR_W'(1);
                    r_state <= F_Z;
                end
                F_Z: begin
                    if (zero_more) begin
                        r_j <= j_next[ADDR_W-1:0];
                    end else begin
                        r_state <= F_NSEL;
                    end
                end
                F_NSEL: r_state <= (h_end < HEAP) ? F_NRD : F_PSEL;
                F_NRD:  r_state <= F_NCHK;
                F_NCHK: begin
                    if (!q_alloc && q_size >= ADDR_W'(2) && sum_n <= HEAP) begin
                        r_s2    <= q_size;
                        r_state <= F_N1;
                    end else begin
                        r_state <= F_PSEL;
                    end
                end
                F_N1: r_state <= F_N2;
                F_N2: begin
                    r_s     <= r_s + r_s2;
                    r_state <= F_N3;
                end
                F_N3: r_state <= F_N4;
                F_N4: r_state <= F_PSEL;
                F_PSEL: begin
                    if (r_h != '0) begin
                        r_state <= F_PRD;
                    end else begin
                        r_out     <= f_res('0, '0, 1'b0, ST_OK, '0, 1'b1);
                        r_o_valid <= 1'b1;
                        r_state   <= S_OUT;
                    end
                end
                F_PRD: r_state <= F_PCHK;
                F_PCHK: begin
                    if (!q_alloc && q_size >= ADDR_W'(2) && q_size <= r_h) begin
                        r_s1    <= q_size;
                        r_state <= F_P1;
                    end else begin
                        r_out     <= f_res('0, '0, 1'b0, ST_OK, '0, 1'b1);
                        r_o_valid <= 1'b1;
                        r_state   <= S_OUT;
                    end
                end
                F_P1: r_state <= F_P2;
                F_P2: r_state <= F_P3;
                F_P3: r_state <= F_P4;
                F_P4, W_DO: begin
                    r_out     <= f_res('0, '0, 1'b0, ST_OK, '0, 1'b1);
                    r_o_valid <= 1'b1;
                    r_state   <= S_OUT;
                end
                R_RD: r_state <= R_Q;
                // The list walk shares the read check state R_Q and branches off on r_listing.
                R_Q: begin
                    r_o_valid <= 1'b1;
                    r_state   <= S_OUT;
                    if (!r_listing) begin
                        r_out <= f_res('0, '0, 1'b0, ST_OK, mem_q, 1'b1);
                    end else if (q_size < ADDR_W'(2) || sum_i > HEAP) begin
                        r_out     <= f_res(r_i + ADDR_W'(1), '0, q_alloc, ST_BAD, '0, 1'b1);
                        r_ret     <= S_IDLE;
                        r_listing <= 1'b0;
                    end else if (sum_i >= HEAP || r_cnt == 6'(MAX_RESULTS - 1)) begin
                        r_out     <= f_res(r_i + ADDR_W'(1), q_size - ADDR_W'(2), q_alloc,
                                           ST_OK, '0, 1'b1);
                        r_ret     <= S_IDLE;
                        r_listing <= 1'b0;
                    end else begin
                        r_out <= f_res(r_i + ADDR_W'(1), q_size - ADDR_W'(2), q_alloc,
                                       ST_OK, '0, 1'b0);
                        r_ret <= L_RD;
                        r_i   <= sum_i[ADDR_W-1:0];
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                L_RD: r_state <= R_Q;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {7'd0, r_out.read_data, r_out.status, r_out.allocated,
                            r_out.payload_size, r_out.address_out};

endmodule
`default_nettype wire

// ===== test/boundary_tag_heap_allocator_test.sv =====
// Self-checking testbench for the boundary-tag heap allocator: a directed table and random
// requests, each result compared against a behavioral heap predictor kept in this file.
// Depends on bth_pkg and the allocator RTL.
`timescale 1ns / 100ps
`default_nettype none
module boundary_tag_heap_allocator_test;
    import bth_pkg::*;

    localparam int HEAP = 127;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [2:0] MODE_UNUSED = 3'd5;

    typedef struct packed {
        logic [6:0] addr;
        logic [6:0] psize;
        logic       alloc;
        logic [1:0] status;
        logic [7:0] rdata;
        logic       last;
    } t_outcome;

    // One row of the directed table; has_exp marks a result typed in by hand.
    typedef struct {
        logic [2:0] mode;
        logic [6:0] req_size;
        logic [6:0] addr;
        logic [7:0] wdata;
        bit         has_exp;
        t_outcome   exp;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // mode[2:0], request_size[9:3], address[16:10], write_data[24:17], zero fill
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // address_out[6:0], payload_size[13:7], allocated[14], status[16:15],
    // read_data[24:17], zero fill
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;

    boundary_tag_heap_allocator #(.HEAP_BYTES(HEAP)) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    // Predictor state: a private copy of the heap bytes.
    logic [7:0] heap_copy [HEAP];
    t_outcome   expected_results [$];
    // Queue for hand-typed results; nothing fills or reads it, check_typed checks the directed rows.
    t_outcome   typed_results [$];

    int  mismatches = 0;
    int  results_seen = 0;
    int  cycles = 0;
    int  send_idle_pct = 19;
    int  recv_idle_pct = 58;
    int  recv_hold = 0;
    int  lists_seen = 0;
    int  allocs_full = 0;

    function automatic int tsize(int i);
        return (i >= HEAP) ? 0 : int'(heap_copy[i][7:1]);
    endfunction

    function automatic bit talloc(int i);
        return (i >= HEAP) ? 1'b1 : heap_copy[i][0];
    endfunction

    function automatic bit sound_tag(int i);
        int s;
        s = tsize(i);
        return i < HEAP && s >= 2 && i + s <= HEAP;
    endfunction

    function automatic void set_tag(int i, int s, bit a);
        if (i < HEAP) heap_copy[i] = {s[6:0], a};
    endfunction

    function automatic void set_byte(int i, logic [7:0] v);
        if (i < HEAP) heap_copy[i] = v;
    endfunction

    function automatic t_outcome outcome(int a, int p, bit al, logic [1:0] st,
                                         logic [7:0] rd, bit l);
        t_outcome o;
        o.addr = a[6:0];
        o.psize = p[6:0];
        o.alloc = al;
        o.status = st;
        o.rdata = rd;
        o.last = l;
        return o;
    endfunction

    function automatic void heap_reset_model();
        for (int i = 0; i < HEAP; i++) heap_copy[i] = 8'h00;
        set_tag(0, HEAP, 1'b0);
        set_tag(HEAP - 1, HEAP, 1'b0);
    endfunction

    // First-fit walk; splits only when at least a two-byte block would remain.
    function automatic void predict_alloc(int req);
        int i, s, need;
        i = 0;
        need = req + 2;
        while (i < HEAP) begin
            if (!sound_tag(i)) break;
            s = tsize(i);
            if (!talloc(i) && s >= need) begin
                if (s - need >= 2) begin
                    set_tag(i, need, 1'b1);
                    set_tag(i + need - 1, need, 1'b1);
                    set_tag(i + need, s - need, 1'b0);
                    set_tag(i + s - 1, s - need, 1'b0);
                end else begin
                    set_tag(i, s, 1'b1);
                    set_tag(i + s - 1, s, 1'b1);
                end
                expected_results.push_back(outcome(i + 1, 0, 0, ST_OK, 0, 1));
                return;
            end
            i += s;
        end
        allocs_full++;
        expected_results.push_back(outcome(0, 0, 0, ST_FULL, 0, 1));
    endfunction

    function automatic void predict_free(int addr);
        int h, s, n, s1, s2;
        if (addr == 0 || addr > HEAP || !sound_tag(addr - 1)) begin
            expected_results.push_back(outcome(0, 0, 0, ST_BAD, 0, 1));
            return;
        end
        h = addr - 1;
        s = tsize(h);
        set_tag(h, s, 1'b0);
        set_tag(h + s - 1, s, 1'b0);
        for (int j = h + 1; j + 1 < h + s; j++) set_byte(j, 8'h00);
        // Merge with the following block when it is free and sound.
        if (h + s < HEAP && !talloc(h + s) && sound_tag(h + s)) begin
            n = h + s;
            s2 = tsize(n);
            set_byte(h + s - 1, 8'h00);
            set_byte(n, 8'h00);
            s += s2;
            set_tag(h, s, 1'b0);
            set_tag(h + s - 1, s, 1'b0);
        end
        // Merge with the preceding block; the first block has no neighbor in front.
        if (h > 0 && !talloc(h - 1)) begin
            s1 = tsize(h - 1);
            if (s1 >= 2 && s1 <= h) begin
                set_byte(h - 1, 8'h00);
                set_byte(h, 8'h00);
                set_tag(h - s1, s1 + s, 1'b0);
                set_tag(h + s - 1, s1 + s, 1'b0);
            end
        end
        expected_results.push_back(outcome(0, 0, 0, ST_OK, 0, 1));
    endfunction

    function automatic void predict_list();
        int i, n, s;
        t_outcome o;
        i = 0;
        n = 0;
        while (i < HEAP && n < MAX_RESULTS) begin
            s = tsize(i);
            if (!sound_tag(i)) begin
                expected_results.push_back(outcome(i + 1, 0, talloc(i), ST_BAD, 0, 0));
                n++;
                break;
            end
            expected_results.push_back(outcome(i + 1, s - 2, talloc(i), ST_OK, 0, 0));
            n++;
            i += s;
        end
        if (n > 0) begin
            o = expected_results.pop_back();
            o.last = 1'b1;
            expected_results.push_back(o);
        end
    endfunction

    function automatic void predict_request(logic [2:0] mode, int req, int addr,
                                            logic [7:0] wd);
        case (mode)
            MODE_ALLOC: predict_alloc(req);
            MODE_FREE:  predict_free(addr);
            MODE_WRITE: begin
                if (addr >= HEAP) begin
                    expected_results.push_back(outcome(0, 0, 0, ST_BAD, 0, 1));
                end else begin
                    heap_copy[addr] = wd;
                    expected_results.push_back(outcome(0, 0, 0, ST_OK, 0, 1));
                end
            end
            MODE_READ: begin
                if (addr >= HEAP)
                    expected_results.push_back(outcome(0, 0, 0, ST_BAD, 0, 1));
                else
                    expected_results.push_back(outcome(0, 0, 0, ST_OK, heap_copy[addr], 1));
            end
            MODE_LIST: begin
                lists_seen++;
                predict_list();
            end
            default: ;
        endcase
    endfunction

    // Result side: random stall, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_outcome got, exp;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = outcome(m_axis_tdata[6:0], m_axis_tdata[13:7], m_axis_tdata[14],
                          m_axis_tdata[16:15], m_axis_tdata[24:17], m_axis_tlast);
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                exp = expected_results.pop_front();
                if (got !== exp || m_axis_tdata[31:25] !== '0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", exp, got);
                end
            end
        end
    end

    // The hand-typed result must also agree with the predictor's view.
    task automatic check_typed(t_outcome want);
        if (expected_results.size() == 0 || expected_results[$] !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("directed row: expected %p", want);
        end
    endtask

    // The request stays offered after its accepting edge until the next request
    // replaces it or an idle cycle drops it, so tvalid changes at most once per edge.
    task automatic send_request(logic [2:0] mode, int req, int addr, logic [7:0] wd);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tdata <= {7'd0, wd, addr[6:0], req[6:0], mode};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_request(mode, req, addr, wd);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // Mostly well-formed traffic: allocs, frees of live blocks, byte traffic, lists.
    task automatic random_phase(int count);
        int live [$];
        int pick, a, r;
        logic [2:0] m;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            a = $urandom_range(127);
            r = ($urandom_range(9) == 0) ? $urandom_range(125) : $urandom_range(20);
            if (pick < 35) begin
                m = MODE_ALLOC;
            end else if (pick < 60) begin
                m = MODE_FREE;
                if (live.size() != 0 && $urandom_range(9) != 0) begin
                    a = live[$urandom_range(live.size() - 1)];
                    live = live.find(x) with (x != a);
                end
            end else if (pick < 72) m = MODE_WRITE;
            else if (pick < 84) m = MODE_READ;
            else if (pick < 97) m = MODE_LIST;
            else m = 3'($urandom_range(7, 5));
            // Writes land anywhere, so tags can get corrupted and the malformed
            // cases of free, alloc and list get exercised.
            send_request(m, r, a, 8'($urandom_range(255)));
            if (m == MODE_ALLOC && expected_results.size() != 0 &&
                expected_results[$].status == ST_OK)
                live.push_back(expected_results[$].addr);
        end
    endtask

    t_row directed [$];

    task automatic add_row(logic [2:0] m, int r, int a, logic [7:0] w,
                           bit typed = 0, t_outcome e = '0);
        t_row row;
        row.mode = m;
        row.req_size = r[6:0];
        row.addr = a[6:0];
        row.wdata = w;
        row.has_exp = typed;
        row.exp = e;
        directed.push_back(row);
    endtask

    initial begin
        heap_reset_model();
        // Directed table: reset state, extremes, error codes and merge cases.
        add_row(MODE_LIST, 0, 0, 0, 1, outcome(1, 125, 0, ST_OK, 0, 1));
        add_row(MODE_READ, 0, 0, 0, 1, outcome(0, 0, 0, ST_OK, 8'hFE, 1));
        add_row(MODE_READ, 0, 126, 0, 1, outcome(0, 0, 0, ST_OK, 8'hFE, 1));
        add_row(MODE_READ, 0, 127, 0, 1, outcome(0, 0, 0, ST_BAD, 0, 1));
        add_row(MODE_WRITE, 0, 127, 8'hFF, 1, outcome(0, 0, 0, ST_BAD, 0, 1));
        add_row(MODE_FREE, 0, 0, 0, 1, outcome(0, 0, 0, ST_BAD, 0, 1));
        add_row(MODE_FREE, 0, 127, 0, 1, outcome(0, 0, 0, ST_BAD, 0, 1));
        add_row(MODE_ALLOC, 126, 0, 0);                       // too big for the heap
        add_row(MODE_ALLOC, 124, 0, 0);                       // near fit, no split
        add_row(MODE_LIST, 0, 0, 0);
        add_row(MODE_FREE, 0, 1, 0, 1, outcome(0, 0, 0, ST_OK, 0, 1));
        add_row(MODE_ALLOC, 125, 0, 0, 1, outcome(1, 0, 0, ST_OK, 0, 1)); // exact fit
        add_row(MODE_FREE, 0, 1, 0);
        add_row(MODE_ALLOC, 0, 0, 0);                         // smallest block
        add_row(MODE_ALLOC, 10, 0, 0);
        add_row(MODE_ALLOC, 5, 0, 0);
        add_row(MODE_WRITE, 0, 5, 8'hAA);
        add_row(MODE_READ, 0, 5, 0);
        add_row(MODE_FREE, 0, 3, 0);                          // both neighbors allocated
        add_row(MODE_FREE, 0, 1, 0);                          // first block, merge after
        add_row(MODE_WRITE, 0, 40, 8'h55);                    // byte inside the free tail
        add_row(MODE_LIST, 0, 0, 0);
        add_row(MODE_FREE, 0, 15, 0);
        add_row(MODE_ALLOC, 100, 0, 0);
        add_row(MODE_UNUSED, 0, 0, 0);                        // ignored mode
        add_row(3'd7, 127, 127, 8'hFF);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        fork
            begin
                foreach (directed[k]) begin
                    send_request(directed[k].mode, directed[k].req_size,
                                 directed[k].addr, directed[k].wdata);
                    if (directed[k].has_exp) check_typed(directed[k].exp);
                end
                wait_drained();

                random_phase(50);
                send_idle_pct = 58;
                recv_idle_pct = 19;
                random_phase(50);
                // Long receiver hold-off while requests keep coming.
                recv_hold <= 400;
                random_phase(10);
                wait_drained();                                // sender pause
                send_idle_pct = 0;
                recv_idle_pct = 0;
                random_phase(50);
                wait_drained();
                repeat (300) @(posedge i_clk);
                $display("Ran directed table and %0d results, %0d lists, %0d full allocs.",
                         results_seen, lists_seen, allocs_full);
                if (mismatches == 0 && expected_results.size() == 0) begin
                    $display("ALL CHECKS PASSED");
                end else begin
                    $display("%0d mismatches, %0d results outstanding", mismatches,
                             expected_results.size());
                    $display("CHECKS FAILED");
                end
                $finish;
            end
            begin
                while (cycles < CYCLE_LIMIT) @(posedge i_clk);
                $display("timeout after %0d cycles", cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        join
    end
endmodule
`default_nettype wire

// ===== boundary_tag_heap_allocator.f =====
design/bth_pkg.sv
design/bth_ram.sv
design/boundary_tag_heap_allocator.sv
test/boundary_tag_heap_allocator_test.sv
